>>> hw/rtl/gclf_pkg.sv
package gclf_pkg;

   localparam int unsigned CHAR_W    = 8;
   localparam int unsigned COUNT_W   = 8;

   localparam logic [COUNT_W-1:0] MAX_LINE_CHARS = COUNT_W'(128);

   localparam logic [CHAR_W-1:0] CHAR_LF     = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_CR     = 8'h0D;
   localparam logic [CHAR_W-1:0] CHAR_SPACE  = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_PCT    = 8'h25;
   localparam logic [CHAR_W-1:0] CHAR_LPAREN = 8'h28;
   localparam logic [CHAR_W-1:0] CHAR_RPAREN = 8'h29;
   localparam logic [CHAR_W-1:0] CHAR_SEMI   = 8'h3B;
   localparam logic [CHAR_W-1:0] CHAR_LOW_A  = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_LOW_Z  = 8'h7A;
   localparam logic [CHAR_W-1:0] CASE_OFFSET = 8'h20;

   typedef logic [CHAR_W-1:0]  char_type;
   typedef logic [COUNT_W-1:0] count_type;

   function automatic char_type upcase(input char_type c);
      if (c >= CHAR_LOW_A && c <= CHAR_LOW_Z) begin
         return char_type'(c - CASE_OFFSET);
      end
      return c;
   endfunction

endpackage

>>> hw/rtl/gclf_req_if.sv
interface gclf_req_if
   import gclf_pkg::*;
();
   logic     valid;
   logic     ready;
   char_type in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

>>> hw/rtl/gclf_rsp_if.sv
interface gclf_rsp_if
   import gclf_pkg::*;
();
   logic     valid;
   logic     ready;
   char_type out_char;
   logic     end_of_line;
   logic     status;

   modport source (output valid, output out_char, output end_of_line, output status,
                   input ready);
   modport sink   (input valid, input out_char, input end_of_line, input status,
                   output ready);
endinterface

>>> hw/rtl/gcode_line_filter_core.sv
// A byte accepted into the input register passes its result word on through the result register.
// Throughput: one byte per cycle while result words are taken; a byte that makes a result
// waits in the input register while the result register holds an untaken word.
// Reset (synchronous, active high) clears both valid flags, the comment flags, the
// kept-character count and the sticky line-too-long error.
module gcode_line_filter_core
   import gclf_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   gclf_req_if.sink       req_chan,
   gclf_rsp_if.source     rsp_chan
);

   logic      in_valid_ff;
   char_type  in_byte_ff;

   logic      paren_ff, paren_in;
   logic      discard_ff, discard_in;
   count_type count_ff, count_in;
   logic      err_ff, err_in;

   logic      rsp_valid_ff;
   char_type  rsp_char_ff;
   logic      rsp_eol_ff;
   logic      rsp_status_ff;

   logic      has_result;
   char_type  res_char;
   logic      res_eol;
   count_type count_inc;
   logic      advance;
   logic      step;

   always_comb begin
      paren_in   = paren_ff;
      discard_in = discard_ff;
      count_in   = count_ff;
      err_in     = err_ff;
      has_result = 1'b0;
      res_char   = in_byte_ff;
      res_eol    = 1'b0;
      count_inc  = (count_ff < MAX_LINE_CHARS) ? count_type'(count_ff + 1'b1) : count_ff;
      priority if (discard_ff) begin
         if (in_byte_ff == CHAR_LF) begin
            discard_in = 1'b0;
         end
      end else if (in_byte_ff == CHAR_SPACE || in_byte_ff == CHAR_CR
                   || in_byte_ff == CHAR_PCT) begin
         // drop filler
      end else if (in_byte_ff == CHAR_LPAREN) begin
         paren_in = 1'b1;
      end else if (in_byte_ff == CHAR_RPAREN) begin
         paren_in = 1'b0;
      end else if (paren_ff) begin
         // skip comment text, terminators included
      end else if (in_byte_ff == CHAR_LF || in_byte_ff == CHAR_SEMI) begin
         if (in_byte_ff == CHAR_SEMI) begin
            discard_in = 1'b1;
         end
         count_in   = '0;
         has_result = (count_ff != '0);
         res_char   = CHAR_LF;
         res_eol    = 1'b1;
      end else begin
         count_in   = count_inc;
         if (count_inc >= MAX_LINE_CHARS) begin
            err_in = 1'b1;
         end
         has_result = 1'b1;
         res_char   = upcase(in_byte_ff);
      end
   end

   // advance the held byte when its result has a free slot, or it makes none
   assign advance = !has_result || !rsp_valid_ff || rsp_chan.ready;
   assign step    = in_valid_ff && advance;

   assign req_chan.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
      if (req_chan.ready && req_chan.valid) begin
         in_byte_ff <= req_chan.in_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         paren_ff   <= 1'b0;
         discard_ff <= 1'b0;
         count_ff   <= '0;
         err_ff     <= 1'b0;
      end else if (step) begin
         paren_ff   <= paren_in;
         discard_ff <= discard_in;
         count_ff   <= count_in;
         err_ff     <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step && has_result) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (step && has_result) begin
         rsp_char_ff   <= res_char;
         rsp_eol_ff    <= res_eol;
         rsp_status_ff <= err_in;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.out_char    = rsp_char_ff;
   assign rsp_chan.end_of_line = rsp_eol_ff;
   assign rsp_chan.status      = rsp_status_ff;

   a_err_sticky: assert property (@(posedge clock) disable iff (reset)
      err_ff |=> err_ff)
      else $error("line-too-long error cleared without reset");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= MAX_LINE_CHARS)
      else $error("kept count above line limit");

   a_eol_char: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_eol_ff |-> rsp_char_ff == CHAR_LF)
      else $error("line end word without newline character");

   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_byte_ff))
      else $error("stalled input byte lost");

   a_status_err: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff |-> err_ff)
      else $error("result status set without error flag");

endmodule

>>> tb/gcode_line_filter_core_tb.sv
`timescale 1ns / 100ps

module gcode_line_filter_core_tb;
   import gclf_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int LONG_HOLD_AT = 400;
   localparam int LONG_HOLD_CYCLES = 300;

   typedef struct packed {
      char_type ch;
      logic     eol;
      logic     err;
   } line_char_type;

   typedef enum int {RX_STREAM, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_mode_type;

   logic clock;
   logic reset;

   gclf_req_if req_bus ();
   gclf_rsp_if rsp_bus ();

   gcode_line_filter_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   char_type      pending_bytes[$];
   line_char_type expected_chars[$];
   int            bytes_queued;
   int            bytes_accepted;
   int            errors;
   int            cycle_count;
   bit            byte_taken;

   // filter state as the block should hold it
   logic       paren_comment;
   logic       semi_comment;
   count_type  line_len;
   logic       too_long;

   string      word_letters = "GMXYZFIJKSTPN";

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic bit filter_byte(input char_type b, output line_char_type w);
      w = '0;
      if (semi_comment) begin
         if (b == CHAR_LF) begin
            semi_comment = 1'b0;
         end
         return 1'b0;
      end
      if (b == CHAR_SPACE || b == CHAR_CR || b == CHAR_PCT) begin
         return 1'b0;
      end
      if (b == CHAR_LPAREN) begin
         paren_comment = 1'b1;
         return 1'b0;
      end
      if (b == CHAR_RPAREN) begin
         paren_comment = 1'b0;
         return 1'b0;
      end
      if (paren_comment) begin
         return 1'b0;
      end
      if (b == CHAR_LF || b == CHAR_SEMI) begin
         if (b == CHAR_SEMI) begin
            semi_comment = 1'b1;
         end
         // an empty line ends silently
         if (line_len == '0) begin
            return 1'b0;
         end
         line_len = '0;
         w = '{ch: CHAR_LF, eol: 1'b1, err: too_long};
         return 1'b1;
      end
      if (line_len < MAX_LINE_CHARS) begin
         line_len = line_len + 1'b1;
      end
      if (line_len >= MAX_LINE_CHARS) begin
         too_long = 1'b1;
      end
      w.ch  = (b >= CHAR_LOW_A && b <= CHAR_LOW_Z) ? char_type'(b - CASE_OFFSET) : b;
      w.eol = 1'b0;
      w.err = too_long;
      return 1'b1;
   endfunction

   // check the output word first, then take the input word, all at the rising edge
   always @(posedge clock) begin : edge_work
      line_char_type want;
      line_char_type got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = '{ch: rsp_bus.out_char, eol: rsp_bus.end_of_line, err: rsp_bus.status};
         if (expected_chars.size() == 0) begin
            errors++;
            $display("%0t: unexpected word, expected none, actual char=%h eol=%b status=%b",
                     $time, got.ch, got.eol, got.err);
         end else begin
            want = expected_chars.pop_front();
            if (got.ch !== want.ch) begin
               errors++;
               $display("%0t: out_char mismatch, expected %h, actual %h",
                        $time, want.ch, got.ch);
            end
            if (got.eol !== want.eol) begin
               errors++;
               $display("%0t: end_of_line mismatch, expected %b, actual %b",
                        $time, want.eol, got.eol);
            end
            if (got.err !== want.err) begin
               errors++;
               $display("%0t: status mismatch, expected %b, actual %b",
                        $time, want.err, got.err);
            end
         end
      end
      byte_taken = !reset && req_bus.valid && req_bus.ready;
      if (byte_taken) begin
         void'(pending_bytes.pop_front());
         bytes_accepted++;
         if (filter_byte(req_bus.in_byte, want)) begin
            expected_chars.push_back(want);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // sender: bursts of random length, random gaps between them
   always @(negedge clock) begin : send_bytes
      int burst_left;
      int gap_left;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (req_bus.valid && !byte_taken) begin
         // hold the word until it is taken
      end else if (pending_bytes.size() != 0 && gap_left == 0) begin
         req_bus.valid   <= 1'b1;
         req_bus.in_byte <= pending_bytes[0];
         if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         end else begin
            burst_left--;
         end
      end else begin
         req_bus.valid <= 1'b0;
         if (gap_left != 0) begin
            gap_left--;
         end
      end
   end

   // receiver: stall pattern redrawn after each run of random length, plus one long hold-off
   always @(negedge clock) begin : take_words
      int          hold_cycles;
      int          mode_left;
      bit          long_hold_done;
      rx_mode_type stall_mode;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_cycles != 0) begin
         rsp_bus.ready <= 1'b0;
         hold_cycles--;
      end else if (!long_hold_done && bytes_accepted >= LONG_HOLD_AT) begin
         long_hold_done = 1'b1;
         hold_cycles    = LONG_HOLD_CYCLES;
         rsp_bus.ready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            stall_mode = rx_mode_type'($urandom_range(0, 3));
            mode_left  = $urandom_range(20, 80);
         end
         mode_left--;
         case (stall_mode)
            RX_STREAM: rsp_bus.ready <= 1'b1;
            RX_COIN:   rsp_bus.ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
            default:   rsp_bus.ready <= ~rsp_bus.ready;
         endcase
      end
   end

   task automatic queue_byte(input char_type b);
      pending_bytes.push_back(b);
      bytes_queued++;
   endtask

   task automatic queue_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         queue_byte(char_type'(s[i]));
      end
   endtask

   task automatic wait_drained();
      while (pending_bytes.size() != 0 || req_bus.valid || expected_chars.size() != 0) begin
         @(negedge clock);
      end
   endtask

   function automatic char_type kept_symbol();
      case ($urandom_range(0, 2))
         0:       return char_type'($urandom_range(8'h30, 8'h39));
         1:       return char_type'($urandom_range(8'h41, 8'h5A));
         default: return char_type'($urandom_range(8'h61, 8'h7A));
      endcase
   endfunction

   task automatic queue_gcode_line();
      int       n_words;
      int       n_digits;
      char_type letter;
      n_words = $urandom_range(1, 5);
      for (int w = 0; w < n_words; w++) begin
         letter = char_type'(word_letters[$urandom_range(0, word_letters.len() - 1)]);
         if ($urandom_range(0, 1) != 0) begin
            letter = letter + CASE_OFFSET;
         end
         queue_byte(letter);
         if ($urandom_range(0, 3) == 0) begin
            queue_text("-");
         end
         n_digits = $urandom_range(1, 4);
         for (int d = 0; d < n_digits; d++) begin
            queue_byte(char_type'($urandom_range(8'h30, 8'h39)));
            if (d == 0 && $urandom_range(0, 3) == 0) begin
               queue_text(".");
            end
         end
         if ($urandom_range(0, 1) != 0) begin
            queue_byte(CHAR_SPACE);
         end
      end
      if ($urandom_range(0, 4) == 0) begin
         queue_byte(CHAR_LPAREN);
         repeat ($urandom_range(0, 6)) queue_byte(char_type'($urandom_range(8'h20, 8'h7E)));
         queue_byte(CHAR_RPAREN);
      end
      if ($urandom_range(0, 5) == 0) begin
         queue_byte(CHAR_SEMI);
         repeat ($urandom_range(0, 6)) queue_byte(char_type'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 3) == 0) begin
         queue_byte(CHAR_CR);
      end
      queue_byte(CHAR_LF);
   endtask

   task automatic queue_random_line();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 72) begin
         queue_gcode_line();
      end else if (pick < 84) begin
         repeat ($urandom_range(1, 8)) queue_byte(char_type'($urandom_range(0, 255)));
      end else if (pick < 90) begin
         // comment left open across the line end
         queue_byte(CHAR_LPAREN);
         queue_gcode_line();
      end else if (pick < 95) begin
         queue_byte(CHAR_RPAREN);
         queue_gcode_line();
      end else if (pick < 97) begin
         queue_byte(CHAR_LF);
      end else if (pick < 99) begin
         queue_byte(CHAR_SPACE);
         queue_byte(CHAR_PCT);
         queue_byte(CHAR_CR);
         queue_byte(CHAR_LF);
      end else begin
         queue_byte(CHAR_SEMI);
         queue_byte(CHAR_LF);
      end
   endtask

   task automatic queue_long_line(input int n_kept);
      // close any open comment and line first, so all n_kept characters count
      queue_byte(CHAR_RPAREN);
      queue_byte(CHAR_LF);
      repeat (n_kept) queue_byte(kept_symbol());
      queue_byte(CHAR_LF);
   endtask

   initial begin
      reset           = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.in_byte = '0;
      rsp_bus.ready   = 1'b0;
      paren_comment   = 1'b0;
      semi_comment    = 1'b0;
      line_len        = '0;
      too_long        = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // dropped bytes, case folding, byte extremes, comments and empty lines
      queue_text("g1 x");
      queue_byte(CHAR_CR);
      queue_text("%)`{");
      queue_byte(8'h00);
      queue_byte(8'hFF);
      queue_text("(a(;\n)\n\n;(b)\nm;x\n");
      wait_drained();

      while (bytes_queued < 700) begin
         queue_random_line();
      end
      wait_drained();

      while (bytes_queued < 1150) begin
         queue_random_line();
      end
      // longest legal line, then the overflow that sets the sticky error
      queue_long_line(int'(MAX_LINE_CHARS) - 1);
      queue_long_line(int'(MAX_LINE_CHARS));
      queue_long_line(int'(MAX_LINE_CHARS) + 12);
      while (bytes_queued < 1700) begin
         queue_random_line();
      end
      wait_drained();
      repeat (8) @(negedge clock);

      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

>>> files.f
hw/rtl/gclf_pkg.sv
hw/rtl/gclf_req_if.sv
hw/rtl/gclf_rsp_if.sv
hw/rtl/gcode_line_filter_core.sv
tb/gcode_line_filter_core_tb.sv
